// File: rtl/core/cswg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine-sum window package
// Shared sizes, codes, window weight sets and the cosine table builder.
// ----------------------------------------------------------------------------
package cswg_pkg;

  // Sizing
  localparam int unsigned MAX_LENGTH = 4096;
  localparam int unsigned PHASE_BITS = 12;
  localparam int unsigned FRAC_BITS  = 16;

  localparam int unsigned IDX_W   = 12;  // sample index
  localparam int unsigned LEN_W   = 13;  // window length register
  localparam int unsigned KIND_W  = 3;   // window kind register
  localparam int unsigned COEF_W  = 18;  // output coefficient
  localparam int unsigned CFG_W   = 13;  // configuration write data

  localparam int unsigned DIV_W   = IDX_W + 1;               // divisor 2*(N-1)
  localparam int unsigned NUM_W   = IDX_W + PHASE_BITS + 1;  // dividend
  localparam int unsigned A_W     = 30;                      // Q30 window weight
  localparam int unsigned COS_W   = 32;                      // signed Q30 cosine
  localparam int unsigned PROD_W  = 64;                      // Q60 sums
  localparam int unsigned NUM_HARM = 4;
  localparam int unsigned NUM_KINDS = 6;
  localparam int unsigned ROM_DEPTH = 2 ** (PHASE_BITS - 1);
  localparam int unsigned ROM_AW    = PHASE_BITS - 1;
  localparam int unsigned Q30_SHIFT = 30;
  localparam int unsigned RND_SHIFT = 60 - FRAC_BITS;

  localparam logic signed [PROD_W-1:0] COEF_MAX = 64'sd131071;
  localparam logic signed [PROD_W-1:0] COEF_MIN = -64'sd131072;
  localparam logic signed [PROD_W-1:0] ONE_RAW  = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [COEF_W-1:0] ONE_COEF =
      COEF_W'((ONE_RAW > COEF_MAX) ? COEF_MAX : ONE_RAW);
  localparam logic signed [PROD_W-1:0] RND_ADD  = 64'sd1 <<< (RND_SHIFT - 1);

  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [COS_W-1:0] NEG_ONE_Q30 = -32'sd1073741824;

  // Register indexes of the configuration port
  typedef enum logic [0:0] {
    REG_WINDOW_KIND   = 1'b0,
    REG_WINDOW_LENGTH = 1'b1
  } cfg_reg_e;

  // Window kinds
  typedef enum logic [KIND_W-1:0] {
    WIN_HANN            = 3'd0,
    WIN_HAMMING         = 3'd1,
    WIN_BLACKMAN        = 3'd2,
    WIN_BLACKMAN_HARRIS = 3'd3,
    WIN_NUTTALL         = 3'd4,
    WIN_FLAT_TOP        = 3'd5
  } window_kind_e;

  // Q30 weights a0..a4 of each kind
  typedef logic [A_W-1:0] kind_row_t [NUM_HARM+1];

  localparam kind_row_t KIND_COEF [NUM_KINDS] = '{
    '{30'd536870912, 30'd536870912, 30'd0,         30'd0,        30'd0},
    '{30'd579820585, 30'd493921239, 30'd0,         30'd0,        30'd0},
    '{30'd450971566, 30'd536870912, 30'd85899346,  30'd0,        30'd0},
    '{30'd385204879, 30'd524297395, 30'd151698245, 30'd12541305, 30'd0},
    '{30'd390393092, 30'd525250341, 30'd146672596, 30'd11425794, 30'd0},
    '{30'd231476135, 30'd447354753, 30'd297709049, 30'd89742211, 30'd7459680}
  };

  // Divisors of the nested Taylor steps, innermost term last
  localparam logic [63:0] TAYLOR_DIV_COS [8] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240
  };
  localparam logic [63:0] TAYLOR_DIV_SIN [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  typedef logic signed [COS_W-1:0] cos_rom_t [ROM_DEPTH];

  function automatic logic [63:0] taylor_q30(logic [63:0] x2, logic is_sin);
    logic [63:0] acc;
    logic [63:0] t;
    acc = ONE_Q30;
    for (int i = 7; i >= 0; i--) begin
      if (is_sin) begin
        t = ((x2 * acc) >> Q30_SHIFT) / TAYLOR_DIV_SIN[i];
      end else begin
        t = ((x2 * acc) >> Q30_SHIFT) / TAYLOR_DIV_COS[i];
      end
      if (t > ONE_Q30) begin
        t = ONE_Q30;
      end
      acc = ONE_Q30 - t;
    end
    return acc;
  endfunction

  // Cosine of f / 2^PHASE_BITS turn, f below half a turn
  function automatic logic signed [COS_W-1:0] cos_entry(int unsigned f);
    logic [63:0] t;
    logic [63:0] r;
    logic [63:0] theta;
    logic [63:0] x2;
    logic [63:0] v;
    logic        neg;
    t     = 64'(f) << (32 - PHASE_BITS);
    neg   = (t >= (64'd1 << 30));
    r     = neg ? (t - (64'd1 << 30)) : t;
    theta = (r * HALF_PI_Q30) >> Q30_SHIFT;
    x2    = (theta * theta) >> Q30_SHIFT;
    if (!neg) begin
      v = taylor_q30(x2, 1'b0);
    end else begin
      v = (theta * taylor_q30(x2, 1'b1)) >> Q30_SHIFT;
      if (v > ONE_Q30) begin
        v = ONE_Q30;
      end
    end
    return neg ? -COS_W'(v) : COS_W'(v);
  endfunction

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    for (int unsigned i = 0; i < ROM_DEPTH; i++) begin
      rom[i] = cos_entry(i);
    end
    return rom;
  endfunction

endpackage

// File: rtl/core/cosine_sum_window_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine-sum window generator
// Pipelined a0 - a1 cos x + a2 cos 2x - a3 cos 3x + a4 cos 4x coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / sample_index_i) carries one
//   sample index n per transaction. Output channel (out_valid_o / out_ready_i)
//   returns one transaction per input: coefficient_o in signed Q16 and
//   index_error_o, set with a zero coefficient when n is not below the
//   window length.
//   The configuration port (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes the
//   window kind or the window length; write it only while no transaction is
//   in flight.
//   Latency: 20 stages, the last of them the output register. Throughput:
//   one transaction per cycle, set by the twelve one-bit stages of the
//   phase divider and the dual-read cosine tables, all fully pipelined,
//   unless the output stalls with every stage full.
//   Reset: pipeline empties, window kind goes to Hann, length to 4096.
//   Stall: when out_ready_i is low the output register holds; upstream
//   stages keep filling any empty slots, so input is still taken until the
//   whole pipeline is full.
// ----------------------------------------------------------------------------
module cosine_sum_window_generator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  cswg_pkg::cfg_reg_e                   cfg_idx_i,
  input  logic [cswg_pkg::CFG_W-1:0]           cfg_wdata_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [cswg_pkg::IDX_W-1:0]           sample_index_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [cswg_pkg::COEF_W-1:0]   coefficient_o,
  output logic                                 index_error_o
);
  import cswg_pkg::*;

  // Stage map: 0 fold, 1..PHASE_BITS divider, then table address, table
  // read, multiply, three adds and the output register.
  localparam int unsigned ST_DIV_LAST = PHASE_BITS;
  localparam int unsigned ST_HARM     = PHASE_BITS + 1;
  localparam int unsigned ST_ROM      = PHASE_BITS + 2;
  localparam int unsigned ST_MUL      = PHASE_BITS + 3;
  localparam int unsigned ST_ADD1     = PHASE_BITS + 4;
  localparam int unsigned ST_ADD2     = PHASE_BITS + 5;
  localparam int unsigned ST_ADD3     = PHASE_BITS + 6;
  localparam int unsigned ST_OUT      = PHASE_BITS + 7;
  localparam int unsigned NUM_STAGES  = PHASE_BITS + 8;

  localparam cos_rom_t COS_ROM_A = build_cos_rom();
  localparam cos_rom_t COS_ROM_B = build_cos_rom();

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [KIND_W-1:0] window_kind_q;
  logic [LEN_W-1:0]  window_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_kind_q   <= KIND_W'(WIN_HANN);
      window_length_q <= LEN_W'(MAX_LENGTH);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW_KIND:   window_kind_q   <= cfg_wdata_i[KIND_W-1:0];
        REG_WINDOW_LENGTH: window_length_q <= cfg_wdata_i[LEN_W-1:0];
        default:           window_kind_q   <= window_kind_q;
      endcase
    end
  end

  // Derived settings, kept static by the user while transactions are in flight
  logic [LEN_W-1:0]  len_eff;
  logic [IDX_W-1:0]  span;      // N-1
  logic [DIV_W-1:0]  divisor;   // 2*(N-1)
  logic [KIND_W-1:0] kind_sel;
  kind_row_t         kind_row;

  always_comb begin
    len_eff  = (window_length_q > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH)
                                                      : window_length_q;
    span     = IDX_W'(len_eff - LEN_W'(1));
    divisor  = {span, 1'b0};
    // unused kinds fall back to Hann
    kind_sel = (window_kind_q > KIND_W'(WIN_FLAT_TOP)) ? KIND_W'(WIN_HANN)
                                                       : window_kind_q;
    kind_row = KIND_COEF[kind_sel];
  end

  // --------------------------------------------------------------------------
  // Flow control: a stage advances when the output is taken or any stage
  // at or after it is empty, so bubbles collapse under a stall.
  // --------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES-1:0] stage_en;
  logic [NUM_STAGES-1:0] err_q;
  logic [NUM_STAGES-1:0] one_q;

  always_comb begin
    for (int unsigned s = 0; s < NUM_STAGES; s++) begin
      stage_en[s] = out_ready_i || (((~vld_q) >> s) != '0);
    end
  end

  assign in_ready_o = stage_en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (stage_en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int unsigned s = 1; s < NUM_STAGES; s++) begin
        if (stage_en[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: range check and fold onto the first half of the window
  // --------------------------------------------------------------------------
  logic             err_d;
  logic             one_d;
  logic [IDX_W-1:0] fold_d;
  logic [NUM_W-1:0] num_d;

  always_comb begin
    err_d  = LEN_W'(sample_index_i) >= len_eff;
    one_d  = (len_eff == LEN_W'(1));
    fold_d = ((LEN_W'(sample_index_i) << 1) > LEN_W'(span)) ? (span - sample_index_i)
                                                            : sample_index_i;
    num_d  = (NUM_W'(fold_d) << (PHASE_BITS + 1)) + NUM_W'(span);
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      err_q[0] <= err_d;
      one_q[0] <= one_d;
    end
    for (int unsigned s = 1; s < NUM_STAGES; s++) begin
      if (stage_en[s]) begin
        err_q[s] <= err_q[s-1];
        one_q[s] <= one_q[s-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 1..PHASE_BITS: restoring divider, one quotient bit per stage
  // --------------------------------------------------------------------------
  logic [NUM_W-1:0]      rem_q [ST_DIV_LAST+1];
  logic [PHASE_BITS-1:0] quo_q [ST_DIV_LAST+1];
  logic [NUM_W-1:0]      rem_d [ST_DIV_LAST+1];
  logic [PHASE_BITS-1:0] quo_d [ST_DIV_LAST+1];

  always_comb begin
    rem_d[0] = num_d;
    quo_d[0] = '0;
    for (int unsigned j = 1; j <= ST_DIV_LAST; j++) begin
      if (rem_q[j-1] >= (NUM_W'(divisor) << (PHASE_BITS - j))) begin
        rem_d[j] = rem_q[j-1] - (NUM_W'(divisor) << (PHASE_BITS - j));
        quo_d[j] = quo_q[j-1] | (PHASE_BITS'(1) << (PHASE_BITS - j));
      end else begin
        rem_d[j] = rem_q[j-1];
        quo_d[j] = quo_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned j = 0; j <= ST_DIV_LAST; j++) begin
      if (stage_en[j]) begin
        rem_q[j] <= rem_d[j];
        quo_q[j] <= quo_d[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Harmonic phases folded onto half a turn
  // --------------------------------------------------------------------------
  localparam logic [PHASE_BITS-1:0] HALF_TURN = PHASE_BITS'(1) << (PHASE_BITS - 1);

  logic [PHASE_BITS-1:0] harm_t [NUM_HARM];
  logic [PHASE_BITS-1:0] harm_f [NUM_HARM];
  logic [ROM_AW-1:0]     addr_q [NUM_HARM];
  logic [NUM_HARM-1:0]   half_q;

  always_comb begin
    harm_t[0] = quo_q[ST_DIV_LAST];
    harm_t[1] = quo_q[ST_DIV_LAST] << 1;
    harm_t[2] = quo_q[ST_DIV_LAST] + (quo_q[ST_DIV_LAST] << 1);
    harm_t[3] = quo_q[ST_DIV_LAST] << 2;
    for (int unsigned h = 0; h < NUM_HARM; h++) begin
      harm_f[h] = (harm_t[h] > HALF_TURN) ? (PHASE_BITS'(0) - harm_t[h]) : harm_t[h];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[ST_HARM]) begin
      for (int unsigned h = 0; h < NUM_HARM; h++) begin
        addr_q[h] <= harm_f[h][ROM_AW-1:0];
        half_q[h] <= (harm_f[h] == HALF_TURN);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Cosine tables, two copies with two read ports each
  // --------------------------------------------------------------------------
  logic signed [COS_W-1:0] cos_q [NUM_HARM];

  always_ff @(posedge clk_i) begin
    if (stage_en[ST_ROM]) begin
      cos_q[0] <= half_q[0] ? NEG_ONE_Q30 : COS_ROM_A[addr_q[0]];
      cos_q[1] <= half_q[1] ? NEG_ONE_Q30 : COS_ROM_A[addr_q[1]];
      cos_q[2] <= half_q[2] ? NEG_ONE_Q30 : COS_ROM_B[addr_q[2]];
      cos_q[3] <= half_q[3] ? NEG_ONE_Q30 : COS_ROM_B[addr_q[3]];
    end
  end

  // --------------------------------------------------------------------------
  // Weighting and Q60 sum
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod_q [NUM_HARM];
  logic signed [PROD_W-1:0] base_q;
  logic signed [PROD_W-1:0] s01_q;
  logic signed [PROD_W-1:0] s23_q;
  logic signed [PROD_W-1:0] p4_q;
  logic signed [PROD_W-1:0] s0123_q;
  logic signed [PROD_W-1:0] p4b_q;
  logic signed [PROD_W-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[ST_MUL]) begin
      base_q <= $signed(PROD_W'(kind_row[0])) <<< Q30_SHIFT;
      for (int unsigned h = 0; h < NUM_HARM; h++) begin
        prod_q[h] <= $signed({1'b0, kind_row[h+1]}) * cos_q[h];
      end
    end
    if (stage_en[ST_ADD1]) begin
      // odd harmonics subtract; fold in the rounding half here
      s01_q <= base_q + RND_ADD - prod_q[0];
      s23_q <= prod_q[1] - prod_q[2];
      p4_q  <= prod_q[3];
    end
    if (stage_en[ST_ADD2]) begin
      s0123_q <= s01_q + s23_q;
      p4b_q   <= p4_q;
    end
    if (stage_en[ST_ADD3]) begin
      sum_q <= s0123_q + p4b_q;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: drop fraction, saturate, apply special cases
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0] shifted;
  logic signed [COEF_W-1:0] coef_d;
  logic signed [COEF_W-1:0] coef_q;

  always_comb begin
    shifted = sum_q >>> RND_SHIFT;
    priority if (err_q[ST_ADD3]) begin
      coef_d = '0;
    end else if (one_q[ST_ADD3]) begin
      coef_d = ONE_COEF;
    end else if (shifted > COEF_MAX) begin
      coef_d = COEF_W'(COEF_MAX);
    end else if (shifted < COEF_MIN) begin
      coef_d = COEF_W'(COEF_MIN);
    end else begin
      coef_d = COEF_W'(shifted);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[ST_OUT]) begin
      coef_q <= coef_d;
    end
  end

  assign out_valid_o   = vld_q[ST_OUT];
  assign coefficient_o = coef_q;
  assign index_error_o = err_q[ST_OUT];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted transaction did not enter the first stage");

  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> ((&vld_q) && !out_ready_i))
    else $error("input held off while the pipeline has room");

  a_phase_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[ST_DIV_LAST] && !err_q[ST_DIV_LAST] && !one_q[ST_DIV_LAST])
      |-> (quo_q[ST_DIV_LAST] <= HALF_TURN))
    else $error("folded phase beyond half a turn");

  a_cos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_ROM] |-> ((cos_q[0] >= NEG_ONE_Q30) && (cos_q[0] <= -NEG_ONE_Q30)))
    else $error("cosine table value out of range");

endmodule

// File: verif/cosine_sum_window_generator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine-sum window generator testbench
// Drives sample indexes through the window generator under several window
// kinds and lengths. Expected coefficients and range flags come from an
// independent fixed-point predictor. Both channel sides idle and stall at
// random while results are compared in order.
// ----------------------------------------------------------------------------
module cosine_sum_window_generator_test;

  import cswg_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 40;    // pipeline is 20 stages deep
  localparam int unsigned RESET_LENGTH = 4096;
  localparam int unsigned PHASES       = 16;
  localparam int unsigned PHASE_ITEMS  = 32;
  localparam int unsigned ROUND_SHIFT  = 60 - FRAC_BITS;

  // Fixed-point angle constants: Q30 unity, pi/2 in Q30, turn fractions in 2^32
  localparam logic [63:0] Q30_ONE      = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_RAD  = 64'd1686629713;
  localparam logic [63:0] FULL_TURN    = 64'd1 << 32;
  localparam logic [63:0] HALF_TURN    = 64'd1 << 31;
  localparam logic [63:0] QUARTER_TURN = 64'd1 << 30;
  localparam longint      SAT_HIGH     = 131071;
  localparam longint      SAT_LOW      = -131072;

  // Kind codes that the block leaves unused; they fall back to Hann
  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

  localparam logic [KIND_W-1:0] KIND_SWEEP [8] = '{
    WIN_HANN, WIN_HAMMING, WIN_BLACKMAN, WIN_BLACKMAN_HARRIS,
    WIN_NUTTALL, WIN_FLAT_TOP, KIND_SPARE_A, KIND_SPARE_B
  };

  // Lengths at the edges: full, shortest real window, clamped, single point,
  // empty, just above the maximum, three points, just below the maximum
  localparam int unsigned EDGE_LENGTHS [8] = '{4096, 2, 8191, 1, 0, 4097, 3, 4095};

  // Published window weights a0..a4 rounded to Q30
  localparam longint WIN_WEIGHTS [6][5] = '{
    '{536870912, 536870912, 0,         0,        0},
    '{579820585, 493921239, 0,         0,        0},
    '{450971566, 536870912, 85899346,  0,        0},
    '{385204879, 524297395, 151698245, 12541305, 0},
    '{390393092, 525250341, 146672596, 11425794, 0},
    '{231476135, 447354753, 297709049, 89742211, 7459680}
  };

  typedef struct {
    logic [IDX_W-1:0]         sample_index;
    logic signed [COEF_W-1:0] coefficient;
    logic                     index_error;
  } coef_result_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_CHOKED
  } rx_mode_e;

  // --------------------------------------------------------------------------
  // Expected-coefficient store with its own copy of the two registers
  // --------------------------------------------------------------------------
  class coef_scoreboard;
    coef_result_t      pending_coefs[$];
    logic [KIND_W-1:0] kind_reg;
    logic [LEN_W-1:0]  length_reg;
    int                mismatches;

    function new();
      kind_reg   = WIN_HANN;
      length_reg = LEN_W'(RESET_LENGTH);
      mismatches = 0;
    endfunction

    function void write_register(cfg_reg_e idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_WINDOW_KIND:   kind_reg = data[KIND_W-1:0];
        REG_WINDOW_LENGTH: length_reg = data[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // Nested Taylor series in Q30; first is 1 for cosine, 2 for sine over x
    function logic [63:0] taylor_chain(logic [63:0] x2, int unsigned first);
      logic [63:0] acc;
      logic [63:0] step;
      logic [63:0] div;
      acc = Q30_ONE;
      for (int k = 8; k >= 1; k--) begin
        div  = 64'((2 * k - 2 + first) * (2 * k - 1 + first));
        step = ((x2 * acc) >> 30) / div;
        if (step > Q30_ONE) step = Q30_ONE;
        acc = Q30_ONE - step;
      end
      return acc;
    endfunction

    // Cosine of ph / 2^PHASE_BITS turn as signed Q30
    function longint cosine_q30(int unsigned ph);
      logic [63:0] t;
      logic [63:0] r;
      logic [63:0] theta;
      logic [63:0] x2;
      logic [63:0] v;
      logic        neg;
      t = 64'(ph) << (32 - PHASE_BITS);
      // fold onto the upper half circle
      if (t > HALF_TURN) t = FULL_TURN - t;
      if (t == HALF_TURN) return -longint'(Q30_ONE);
      // second quarter: cos(q + r) = -sin(r)
      neg   = (t >= QUARTER_TURN);
      r     = neg ? t - QUARTER_TURN : t;
      theta = (r * HALF_PI_RAD) >> 30;
      x2    = (theta * theta) >> 30;
      if (!neg) begin
        v = taylor_chain(x2, 1);
      end else begin
        v = (theta * taylor_chain(x2, 2)) >> 30;
        if (v > Q30_ONE) v = Q30_ONE;
      end
      return neg ? -longint'(v) : longint'(v);
    endfunction

    function coef_result_t window_coefficient(logic [IDX_W-1:0] n);
      coef_result_t res;
      int unsigned  len;
      int unsigned  d;
      int unsigned  m;
      int unsigned  phase;
      int unsigned  sel;
      longint       sum;
      longint       term;
      longint       val;
      logic [63:0]  u;
      res.sample_index = n;
      res.index_error  = 1'b0;
      res.coefficient  = '0;
      len = (length_reg > MAX_LENGTH) ? MAX_LENGTH : int'(length_reg);
      if (n >= len) begin
        res.index_error = 1'b1;
        return res;
      end
      if (len == 1) begin
        val = longint'(1) << FRAC_BITS;
      end else begin
        // mirror into the first half, then quantize n/(N-1) to a phase
        d     = len - 1;
        m     = (2 * n > d) ? d - n : n;
        phase = (((m << (PHASE_BITS + 1)) + d) / (2 * d)) % (1 << PHASE_BITS);
        sel   = (kind_reg > WIN_FLAT_TOP) ? WIN_HANN : kind_reg;
        sum   = WIN_WEIGHTS[sel][0] * longint'(Q30_ONE);
        for (int k = 1; k <= NUM_HARM; k++) begin
          term = WIN_WEIGHTS[sel][k] * cosine_q30((k * phase) % (1 << PHASE_BITS));
          if (k % 2 == 1) sum -= term;
          else sum += term;
        end
        // round half up from Q60 through an offset that keeps the sum positive
        u   = 64'(sum) + (64'd1 << 61);
        u   = (u + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
        val = longint'(u) - (longint'(1) << (FRAC_BITS + 1));
      end
      if (val > SAT_HIGH) val = SAT_HIGH;
      if (val < SAT_LOW) val = SAT_LOW;
      res.coefficient = val[COEF_W-1:0];
      return res;
    endfunction

    function void note_index(logic [IDX_W-1:0] n);
      pending_coefs.push_back(window_coefficient(n));
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_coefficient(logic signed [COEF_W-1:0] coef, logic err);
      coef_result_t want;
      if (pending_coefs.size() == 0) begin
        report_mismatch($sformatf("unexpected result coef %0d err %0d", coef, err));
        return;
      end
      want = pending_coefs.pop_front();
      if (coef !== want.coefficient)
        report_mismatch($sformatf("index %0d coefficient got %0d want %0d",
                                  want.sample_index, coef, want.coefficient));
      if (err !== want.index_error)
        report_mismatch($sformatf("index %0d index_error got %0d want %0d",
                                  want.sample_index, err, want.index_error));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Block under test and its drive signals
  // --------------------------------------------------------------------------
  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              cfg_we_i       = 1'b0;
  cfg_reg_e          cfg_idx_i      = REG_WINDOW_KIND;
  logic [CFG_W-1:0]  cfg_wdata_i    = '0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [IDX_W-1:0]  sample_index_i = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic signed [COEF_W-1:0] coefficient_o;
  logic              index_error_o;

  cosine_sum_window_generator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_index_i(sample_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .coefficient_o (coefficient_o),
    .index_error_o (index_error_o)
  );

  coef_scoreboard coefs = new();

  logic        in_fire    = 1'b0;  // input transaction seen at the last rising edge
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  rx_mode_e    rx_mode    = RX_OPEN;
  int unsigned rx_left    = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Monitor: sample everything at the rising edge, before the block updates.
  // Register writes land in the predictor copy at the same edge the block
  // takes them, so a transaction accepted later sees the new setting.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    in_fire = rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && cfg_we_i) coefs.write_register(cfg_idx_i, cfg_wdata_i);
    if (in_fire) coefs.note_index(sample_index_i);
    if (rst_ni && out_valid_o && out_ready_i)
      coefs.check_coefficient(coefficient_o, index_error_o);
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL cosine_sum_window_generator");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: switch among stall patterns at random so that back-pressure
  // reaches every depth of the pipeline, with open stretches.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 96);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:   out_ready_i <= 1'b1;
      RX_COIN:   out_ready_i <= 1'($urandom);
      RX_SPARSE: out_ready_i <= ($urandom_range(0, 7) != 0);
      default:   out_ready_i <= ($urandom_range(0, 11) == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Sender: present one index and hold it until the transaction happens.
  // Bursts of random length; between bursts drop valid for a random gap.
  // Called and returning at a falling edge.
  // --------------------------------------------------------------------------
  task automatic send_index(logic [IDX_W-1:0] idx);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      // long bursts give stretches with no idling at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    sample_index_i <= idx;
    do @(negedge clk_i); while (!in_fire);
  endtask

  // Drop valid and wait until every expected coefficient has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (coefs.pending_coefs.size() != 0) @(negedge clk_i);
  endtask

  // Write both registers while the pipeline is empty; the unused upper data
  // bits of the kind write carry random noise that the block must drop
  task automatic set_window(logic [KIND_W-1:0] kind, int unsigned len);
    wait_drained();
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_WINDOW_KIND;
    cfg_wdata_i <= {(CFG_W - KIND_W)'($urandom), kind};
    @(negedge clk_i);
    cfg_idx_i   <= REG_WINDOW_LENGTH;
    cfg_wdata_i <= CFG_W'(len);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned len;
    int unsigned reach;
    logic [KIND_W-1:0] kind;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset setting, Hann over 4096 points: both ends, the center pair, a third
    send_index(12'd0);
    send_index(12'd4095);
    send_index(12'd2047);
    send_index(12'd2048);
    send_index(12'd1365);

    // Single point: index zero is exactly one, anything else is out of range
    set_window(WIN_HAMMING, 1);
    send_index(12'd0);
    send_index(12'd1);
    send_index(12'd4095);

    // Empty window: every index flags
    set_window(WIN_BLACKMAN, 0);
    send_index(12'd0);
    send_index(12'd4095);

    // Length register beyond the maximum clamps to the full window
    set_window(WIN_FLAT_TOP, 8191);
    send_index(12'd4095);
    send_index(12'd0);

    // Every kind, spare codes included, at the center of a nine-point window
    for (int i = 0; i < 8; i++) begin
      set_window(KIND_SWEEP[i], 9);
      send_index(12'd4);
    end

    // Random phases: edge lengths and every kind first, then random settings
    for (int p = 0; p < PHASES; p++) begin
      if (p < 8) begin
        kind = KIND_SWEEP[p];
        len  = EDGE_LENGTHS[p];
      end else begin
        kind = KIND_SWEEP[$urandom_range(0, 7)];
        len  = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 64)
                                           : $urandom_range(1, MAX_LENGTH);
      end
      set_window(kind, len);
      reach = (len > MAX_LENGTH) ? MAX_LENGTH : len;
      // mostly indexes inside the window, the rest anywhere in the field
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (reach > 0 && $urandom_range(0, 9) < 8)
          send_index(IDX_W'($urandom_range(0, reach - 1)));
        else
          send_index(IDX_W'($urandom));
      end
    end

    // Let the pipeline empty, then watch for stray results
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    while (coefs.pending_coefs.size() != 0) begin
      coefs.report_mismatch($sformatf("no result for index %0d",
                                      coefs.pending_coefs[0].sample_index));
      void'(coefs.pending_coefs.pop_front());
    end

    if (coefs.mismatches == 0) begin
      $display("PASS cosine_sum_window_generator");
    end else begin
      $display("FAIL cosine_sum_window_generator");
    end
    $finish;
  end

endmodule
